// ----- rtl/gmd_pkg.sv -----
// shared types and constants for the geometric mean degree block
package gmd_pkg;

	localparam int PointerBits = 32;
	localparam int LogFracBits = 16;
	localparam int OutFracBits = 16;
	localparam int LogSumBits  = 56;
	localparam int GeoBits     = 48;
	localparam int FracCntBits = $clog2(LogFracBits + 1);
	localparam int DivCntBits  = $clog2(LogSumBits + 1);
	localparam int SrchCntBits = 6;

	localparam logic [1:0] StatusOk       = 2'd0;
	localparam logic [1:0] StatusZeroDeg  = 2'd1;
	localparam logic [1:0] StatusNoVertex = 2'd2;
	localparam logic [1:0] StatusDecrease = 2'd3;

	typedef struct packed {
		logic [31:0] row_pointer;
		logic        last;
	} in_item_t;

	typedef struct packed {
		logic [GeoBits-1:0] geo_mean;
		logic [31:0]        vertex_count;
		logic [1:0]         status;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIRST,
		ST_LOG_SQ,
		ST_LOG_FIX,
		ST_ACC,
		ST_DIV,
		ST_SRCH_INIT,
		ST_SRCH_SQ,
		ST_SRCH_FIX,
		ST_SRCH_STEP,
		ST_RESULT,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;     // take the input item into the datapath
		logic log_start;   // load mantissa for the degree log
		logic sq_load;     // square the working mantissa into the product register
		logic sq_fix;      // normalize product and shift one fraction bit in
		logic acc;         // update log sum, vertex count and error state
		logic div_start;
		logic div_step;
		logic srch_init;
		logic srch_mid;    // load mid into the log unit
		logic srch_step;
		logic result;      // build the result and clear the state
		logic out_take;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_log;    // a previous pointer exists, degree is positive and pointer did not drop
		logic is_last;
		logic have_prev;
		logic frac_done;
		logic div_done;
		logic srch_done;
		logic want_exp;
	} stat_t;

endpackage

// ----- rtl/geometric_mean_degree_csr.sv -----
// top level of the geometric mean degree block
//  channel | direction | payload
//  in      | input     | in_item_t  (row_pointer, last)
//  out     | output    | out_item_t (geo_mean, vertex_count, status)
// one entry at a time; a degree entry takes a log of 16 squarings
// in the log unit, an empty-degree entry skips the log
// the last entry adds a division and, for an ok status, a search of up to 32 steps, each
// step a 16-squaring log; reset clears all matrix state
// the result holds in its register until taken; no entry is taken meanwhile
module geometric_mean_degree_csr (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  gmd_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output gmd_pkg::out_item_t  out_data
);
	import gmd_pkg::*;

	cmd_t  cmd;
	stat_t st;

	gmd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_ready(out_ready), .out_valid(out_valid), .st(st), .cmd(cmd)
	);

	gmd_dp u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .cmd(cmd), .st(st),
		.out_item(out_data)
	);

endmodule

// ----- rtl/gmd_ctrl.sv -----
// controller state machine for the geometric mean degree block
module gmd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          out_ready,
	output logic          out_valid,
	input  gmd_pkg::stat_t st,
	output gmd_pkg::cmd_t  cmd
);
	import gmd_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (in_valid) state_d = ST_FIRST;
			ST_FIRST:     state_d = st.need_log ? ST_LOG_SQ : ST_ACC;
			ST_LOG_SQ:    state_d = ST_LOG_FIX;
			ST_LOG_FIX:   state_d = st.frac_done ? ST_ACC : ST_LOG_SQ;
			ST_ACC:       state_d = st.is_last ? ST_DIV : ST_IDLE;
			ST_DIV: begin
				if (st.div_done) state_d = st.want_exp ? ST_SRCH_INIT : ST_RESULT;
			end
			ST_SRCH_INIT: state_d = st.srch_done ? ST_RESULT : ST_SRCH_SQ;
			ST_SRCH_SQ:   state_d = ST_SRCH_FIX;
			ST_SRCH_FIX:  state_d = st.frac_done ? ST_SRCH_STEP : ST_SRCH_SQ;
			ST_SRCH_STEP: state_d = ST_SRCH_INIT;
			ST_RESULT:    state_d = ST_OUT;
			ST_OUT:       if (out_ready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
			end
			ST_FIRST:     cmd.log_start = 1'b1;
			ST_LOG_SQ:    cmd.sq_load = 1'b1;
			ST_LOG_FIX:   cmd.sq_fix = 1'b1;
			ST_ACC: begin
				cmd.acc = 1'b1;
				cmd.div_start = st.is_last;
			end
			ST_DIV:       cmd.div_step = 1'b1;
			ST_SRCH_INIT: cmd.srch_mid = 1'b1;
			ST_SRCH_SQ:   cmd.sq_load = 1'b1;
			ST_SRCH_FIX:  cmd.sq_fix = 1'b1;
			ST_SRCH_STEP: cmd.srch_step = 1'b1;
			ST_RESULT:    cmd.result = 1'b1;
			ST_OUT: begin
				out_valid = 1'b1;
				cmd.out_take = out_ready;
			end
			default: ;
		endcase
	end

	// srch_init unused as separate strobe; the division finishing sets bounds
	logic unused_init;
	assign unused_init = cmd.srch_init;

endmodule

// ----- rtl/gmd_dp.sv -----
// datapath: degree log, log sum, divider and exp2 search
module gmd_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  gmd_pkg::in_item_t   in_item,
	input  gmd_pkg::cmd_t       cmd,
	output gmd_pkg::stat_t      st,
	output gmd_pkg::out_item_t  out_item
);
	import gmd_pkg::*;

	logic [PointerBits-1:0] prev_q, ptr_q;
	logic                   have_prev_q, last_q;
	logic [LogSumBits-1:0]  log_sum_q;
	logic [31:0]            verts_q;
	logic [1:0]             err_q;

	// shared log unit
	logic [32:0]            m_q;      // mantissa, Q1.31 plus headroom
	logic [65:0]            prod_q;
	logic [LogFracBits-1:0] frac_q;
	logic [FracCntBits-1:0] fcnt_q;
	logic [4:0]             k_q;

	// divider
	logic [LogSumBits-1:0]  quot_q, rem_q;
	logic [DivCntBits-1:0]  dcnt_q;

	// search
	logic [32:0]            lo_q, hi_q;

	out_item_t out_q;

	logic [PointerBits-1:0] deg;
	logic                   drop;
	logic [4:0]             kfind;
	logic [65:0]            sq;
	logic [34:0]            msh;
	logic [32:0]            mid;
	logic [LogSumBits:0]    sum_ext;
	logic [LogSumBits:0]    rem_sh;
	logic [LogSumBits-1:0]  fmask_q;
	logic [4:0]             iexp;
	logic [95:0]            shifted;
	logic [95:0]            geo_w;
	logic [31:0]            lo_c;
	logic [31:0]            verts_n;
	logic [LogSumBits-1:0]  lval;

	assign deg  = ptr_q - prev_q;
	assign drop = ptr_q < prev_q;

	always_comb begin
		kfind = '0;
		for (int b = 0; b < PointerBits; b++) begin
			if (deg[b]) kfind = 5'(b);
		end
	end

	assign sq  = 66'(m_q) * 66'(m_q);
	assign msh = prod_q[65:31];
	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	assign lval    = LogSumBits'({k_q, frac_q});
	assign sum_ext = {1'b0, log_sum_q} + {1'b0, lval};
	assign verts_n = (verts_q == '1) ? verts_q : verts_q + 32'd1;
	assign rem_sh  = {rem_q, quot_q[LogSumBits-1]};
	assign fmask_q = LogSumBits'((1 << LogFracBits) - 1);
	assign iexp    = (quot_q[LogSumBits-1:LogFracBits] > 31) ? 5'd31 :
		5'(quot_q[LogSumBits-1:LogFracBits]);
	assign lo_c    = (lo_q[32]) ? 32'hFFFF_FFFF : lo_q[31:0];
	assign shifted = 96'(lo_c) << iexp;
	assign geo_w   = shifted >> (31 - OutFracBits);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ptr_q  <= in_item.row_pointer[PointerBits-1:0];
			last_q <= in_item.last;
		end
		if (cmd.log_start) begin
			k_q    <= kfind;
			m_q    <= 33'(deg) << (5'd31 - kfind);
			frac_q <= '0;
			fcnt_q <= '0;
		end
		if (cmd.srch_mid) begin
			m_q    <= mid;
			frac_q <= '0;
			fcnt_q <= '0;
		end
		if (cmd.sq_load) prod_q <= sq;
		if (cmd.sq_fix) begin
			frac_q <= {frac_q[LogFracBits-2:0], msh[33] | msh[32]};
			m_q    <= (msh[33] | msh[32]) ? msh[33:1] : msh[32:0];
			fcnt_q <= fcnt_q + 1'b1;
		end
		if (cmd.div_start) begin
			quot_q <= (sum_ext[LogSumBits] || !st.need_log) ?
				(st.need_log ? '1 : log_sum_q) : sum_ext[LogSumBits-1:0];
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step && !st.div_done) begin
			if (rem_sh >= {25'd0, verts_q}) begin
				rem_q <= LogSumBits'(rem_sh - {25'd0, verts_q});
				quot_q <= {quot_q[LogSumBits-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[LogSumBits-1:0];
				quot_q <= {quot_q[LogSumBits-2:0], 1'b0};
			end
			dcnt_q <= dcnt_q + 1'b1;
		end
		if (cmd.div_step && st.div_done) begin
			lo_q <= 33'h0_8000_0000;
			hi_q <= 33'h1_0000_0000;
		end
		if (cmd.srch_step) begin
			if (LogSumBits'(frac_q) >= (quot_q & fmask_q)) hi_q <= mid;
			else lo_q <= mid + 33'd1;
		end
		if (cmd.result) begin
			out_q.vertex_count <= verts_q;
			if (err_q == StatusDecrease) out_q.status <= StatusDecrease;
			else if (verts_q == '0) out_q.status <= StatusNoVertex;
			else if (err_q == StatusZeroDeg) out_q.status <= StatusZeroDeg;
			else out_q.status <= StatusOk;
			out_q.geo_mean <= (err_q != StatusOk || verts_q == '0) ? '0 :
				(geo_w[95:GeoBits] != '0) ? '1 : geo_w[GeoBits-1:0];
		end
	end

	// architectural state of the running matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			have_prev_q <= 1'b0;
			log_sum_q <= '0;
			verts_q <= '0;
			err_q <= StatusOk;
		end else if (cmd.acc) begin
			if (have_prev_q) begin
				if (drop) err_q <= StatusDecrease;
				else if (deg == '0 && err_q != StatusDecrease) err_q <= StatusZeroDeg;
				if (st.need_log) log_sum_q <= sum_ext[LogSumBits] ? '1 :
					sum_ext[LogSumBits-1:0];
				verts_q <= verts_n;
			end
			prev_q <= ptr_q;
			have_prev_q <= 1'b1;
		end else if (cmd.result) begin
			prev_q <= '0;
			have_prev_q <= 1'b0;
			log_sum_q <= '0;
			verts_q <= '0;
			err_q <= StatusOk;
		end
	end

	// divisor comes from verts_q; the counter was updated in the acc cycle
	assign st.need_log  = have_prev_q && !drop && deg != '0;
	assign st.is_last   = last_q;
	assign st.have_prev = have_prev_q;
	// high during the fix cycle that shifts in the final fraction bit
	assign st.frac_done = fcnt_q == FracCntBits'(LogFracBits - 1);
	assign st.div_done  = dcnt_q == DivCntBits'(LogSumBits);
	assign st.srch_done = lo_q >= hi_q;
	assign st.want_exp  = err_q == StatusOk && verts_q != '0;

	assign out_item = out_q;

	logic unused_take;
	assign unused_take = cmd.out_take;

endmodule

// ----- rtl/gmd_checker.sv -----
// port-level checks for the geometric mean degree block
module gmd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input gmd_pkg::out_item_t out_data
);
	import gmd_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_no_in_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while result pending");

	a_geo_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != StatusOk |-> out_data.geo_mean == '0)
		else $error("nonzero mean with error status");

	a_novert: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == StatusNoVertex |-> out_data.vertex_count == '0)
		else $error("no-vertex status with vertices");

endmodule

bind geometric_mean_degree_csr gmd_checker u_gmd_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ----- tb/tb_geometric_mean_degree_csr.sv -----
// testbench for the geometric mean degree block: scoreboard prediction, random and directed csr arrays
module tb_geometric_mean_degree_csr;
	timeunit 1ns;
	timeprecision 1ps;
	import gmd_pkg::*;

	localparam longint unsigned LogSumMax = (64'd1 << LogSumBits) - 1;
	localparam longint unsigned GeoMax    = (64'd1 << GeoBits) - 1;
	localparam longint unsigned Two31     = 64'd1 << 31;
	localparam longint unsigned Two32     = 64'd1 << 32;
	localparam int              IdleLimit = 20000;

	// fractional log2 of a q1.31 mantissa
	function automatic longint unsigned mant_log_frac(longint unsigned m);
		longint unsigned frac;
		frac = 0;
		for (int j = 0; j < LogFracBits; j++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= Two32) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		return frac;
	endfunction

	function automatic longint unsigned degree_log2(logic [31:0] d);
		int k;
		k = 0;
		while (k < 31 && (d >> (k + 1)) != 0)
			k++;
		return (longint'(k) << LogFracBits) | mant_log_frac(longint'(d) << (31 - k));
	endfunction

	function automatic longint unsigned pow2_mean(longint unsigned q);
		longint unsigned ip, f, lo, hi, mid, r;
		ip = q >> LogFracBits;
		f = q & ((64'd1 << LogFracBits) - 1);
		lo = Two31;
		hi = Two32;
		if (ip > 31)
			ip = 31;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (mant_log_frac(mid) >= f)
				hi = mid;
			else
				lo = mid + 1;
		end
		if (lo >= Two32)
			lo = Two32 - 1;
		r = (lo << ip) >> (31 - OutFracBits);
		if (r > GeoMax)
			r = GeoMax;
		return r;
	endfunction

	class degree_scoreboard;
		logic [31:0]     prev_ptr;
		bit              have_prev;
		longint unsigned log_sum;
		logic [31:0]     vertices;
		logic [1:0]      err;
		out_item_t       pending[$];
		int              errors;

		function void clear();
			prev_ptr = 0;
			have_prev = 0;
			log_sum = 0;
			vertices = 0;
			err = StatusOk;
		endfunction

		function void note_entry(in_item_t it);
			out_item_t r;
			logic [31:0] d;
			longint unsigned l;
			if (have_prev) begin
				if (it.row_pointer < prev_ptr) begin
					err = StatusDecrease;
				end else begin
					d = it.row_pointer - prev_ptr;
					if (d == 0) begin
						if (err != StatusDecrease)
							err = StatusZeroDeg;
					end else begin
						l = degree_log2(d);
						if (log_sum > LogSumMax - l)
							log_sum = LogSumMax;
						else
							log_sum = log_sum + l;
					end
				end
				if (vertices != 32'hffffffff)
					vertices++;
			end
			prev_ptr = it.row_pointer;
			have_prev = 1;
			if (!it.last)
				return;
			r.vertex_count = vertices;
			if (err == StatusDecrease)
				r.status = StatusDecrease;
			else if (vertices == 0)
				r.status = StatusNoVertex;
			else if (err == StatusZeroDeg)
				r.status = StatusZeroDeg;
			else
				r.status = StatusOk;
			r.geo_mean = 0;
			if (r.status == StatusOk)
				r.geo_mean = GeoBits'(pow2_mean(log_sum / longint'(vertices)));
			pending.push_back(r);
			clear();
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp_r;
			if (pending.size() == 0) begin
				$error("unexpected result %h", got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.geo_mean !== exp_r.geo_mean) begin
				$error("geo_mean expected %h got %h", exp_r.geo_mean, got.geo_mean);
				errors++;
			end
			if (got.vertex_count !== exp_r.vertex_count) begin
				$error("vertex_count expected %h got %h", exp_r.vertex_count,
					got.vertex_count);
				errors++;
			end
			if (got.status !== exp_r.status) begin
				$error("status expected %h got %h", exp_r.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	degree_scoreboard sb;
	int  send_idle_pct;
	int  recv_idle_pct;
	int  idle_cycles;
	bit  timed_out;

	geometric_mean_degree_csr uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// receiver side and checking
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(out_data);
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > IdleLimit) begin
				$display("geometric_mean_degree_csr regression: fail");
				$finish;
			end
		end
	end

	// valid drops only on idle cycles, so a back-to-back transaction drives it once
	task automatic send_entry(logic [31:0] ptr, logic lst);
		in_item_t it;
		it.row_pointer = ptr;
		it.last = lst;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_entry(it);
	endtask

	// one array: n entries starting at base, degree limited by dmax except for noise jumps
	task automatic send_array(int n, logic [31:0] base, logic [31:0] dmax, int noise);
		logic [31:0] p;
		p = base;
		for (int i = 0; i < n; i++) begin
			send_entry(p, i == n - 1);
			if ($urandom_range(99) < noise)
				p = $urandom;
			else
				p = p + $urandom_range(dmax);
		end
	endtask

	int items;

	initial begin
		sb = new();
		sb.clear();
		sb.errors = 0;
		in_valid = 0;
		in_data = '0;
		out_ready = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		idle_cycles = 0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: single entry, extremes, zero degree, decrease
		send_entry(32'd0, 1);
		send_entry(32'hffffffff, 1);
		send_entry(32'd0, 0);
		send_entry(32'hffffffff, 1);
		send_entry(32'd5, 0);
		send_entry(32'd6, 1);
		send_entry(32'd10, 0);
		send_entry(32'd10, 0);
		send_entry(32'd20, 1);
		send_entry(32'd100, 0);
		send_entry(32'd50, 0);
		send_entry(32'd50, 1);
		send_entry(32'd0, 0);
		send_entry(32'h80000000, 0);
		send_entry(32'hffffffff, 1);
		send_entry(32'd0, 0);
		send_entry(32'd3, 0);
		send_entry(32'd10, 0);
		send_entry(32'd11, 1);
		send_entry(32'haaaaaaaa, 0);
		send_entry(32'h55555555, 1);

		items = 0;
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 49 : 0;
			recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 25 : 0;
			while (items < (ph + 1) * 165) begin
				int n;
				int kind;
				n = $urandom_range(8, 1);
				kind = $urandom_range(9);
				if (kind < 6)
					send_array(n, $urandom_range(1000), $urandom_range(1, 64) , 0);
				else if (kind < 8)
					send_array(n, $urandom, $urandom, 0);
				else
					send_array(n, $urandom, $urandom_range(4), 30);
				items += n;
			end
		end
		in_valid <= 0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("geometric_mean_degree_csr regression: pass");
		else
			$display("geometric_mean_degree_csr regression: fail");
		$finish;
	end
endmodule
